[hw/rtl/lbsd_pkg.sv]
// Shared types, constants and lookup tables of the LED bar graph scan driver.
package lbsd_pkg;

  // Band table geometry: entry i is round(BAND_LO + i*(BAND_HI-BAND_LO)/(BAND_COUNT-1))
  localparam int BAND_COUNT = 32;
  localparam int BAND_IW    = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int BAND_W     = 13;
  localparam int BAND_LO    = 250;
  localparam int BAND_HI    = 5000;
  localparam int BAND_DEN   = 2 * (BAND_COUNT - 1);

  // Widths of the level search
  localparam int PPM_W   = 20;
  localparam int ACC_W   = 16;
  localparam int LEVEL_W = 3;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd6;

  typedef logic [BAND_W-1:0] band_table_t [BAND_COUNT];

  // Build the band thresholds at elaboration
  function automatic band_table_t band_init();
    band_table_t t;
    for (int i = 0; i < BAND_COUNT; i++) begin
      t[i] = BAND_W'((BAND_LO * BAND_DEN + i * (BAND_HI - BAND_LO) * 2 + (BAND_COUNT - 1))
                     / BAND_DEN);
    end
    return t;
  endfunction

  localparam band_table_t BAND_TABLE = band_init();

  // Charlieplex line combinations per scan position
  localparam logic [2:0] DRIVE_ROM  [8] = '{3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd1, 3'd5, 3'd1};
  localparam logic [2:0] COMMON_ROM [8] = '{3'd6, 3'd1, 3'd3, 3'd5, 3'd6, 3'd3, 3'd5, 3'd6};

  // Bar graph pattern per level
  localparam logic [7:0] LEVEL_ROM [7] = '{8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF9, 8'hFC};

  // Display modes
  localparam logic [2:0] MODE_BEEP       = 3'd0;
  localparam logic [2:0] MODE_POWER_UP   = 3'd1;
  localparam logic [2:0] MODE_AIR_ZERO   = 3'd2;
  localparam logic [2:0] MODE_ZERO_CHECK = 3'd3;
  localparam logic [2:0] MODE_SLEEP      = 3'd4;

  // Fixed LED patterns
  localparam logic [7:0] PAT_ALL     = 8'hFF;
  localparam logic [7:0] PAT_OFF     = 8'h00;
  localparam logic [7:0] PAT_AIR_HI  = 8'h54;
  localparam logic [7:0] PAT_AIR_LO  = 8'hA8;
  localparam logic [7:0] PAT_ZC_HI   = 8'h1C;
  localparam logic [7:0] PAT_ZC_LO   = 8'hE0;
  localparam logic [7:0] LED_ALARM   = 8'h01;
  localparam logic [7:0] LED_BATTERY = 8'h02;

  localparam logic [2:0] ANIM_START     = 3'd7;
  localparam logic [9:0] THRESH_DEFAULT = 10'd512;

  // Level unit control and status
  typedef struct packed {
    logic start;
  } lbsd_lvl_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lbsd_lvl_sts_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } lbsd_state_t;

endpackage

[hw/rtl/lbsd_level_unit.sv]
// Iterative bar graph level search: one add and compare per cycle.
module lbsd_level_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  lbsd_pkg::lbsd_lvl_ctl_t       ctl,
  input  logic [lbsd_pkg::PPM_W-1:0]    ppm,
  input  logic [lbsd_pkg::BAND_W-1:0]   band,
  output lbsd_pkg::lbsd_lvl_sts_t       sts,
  output logic [lbsd_pkg::LEVEL_W-1:0]  level
);
  import lbsd_pkg::*;

  logic [PPM_W-1:0]   ppm_q;
  logic [BAND_W-1:0]  band_q;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_next;
  logic [LEVEL_W-1:0] level_next;
  logic               busy;
  logic               busy_next;
  logic               done;
  logic               done_next;
  logic               step_ok;

  // Advance while the next multiple of the band still fits under the reading
  assign step_ok = (level != LEVEL_MAX) && (ppm_q >= PPM_W'(acc));

  always_comb begin
    acc_next   = acc;
    level_next = level;
    busy_next  = busy;
    done_next  = 1'b0;
    if (ctl.start) begin
      acc_next   = ACC_W'(band);
      level_next = '0;
      busy_next  = 1'b1;
    end else if (busy) begin
      if (step_ok) begin
        acc_next   = acc + ACC_W'(band_q);
        level_next = level + 1'b1;
      end else begin
        busy_next = 1'b0;
        done_next = 1'b1;
      end
    end
  end

  // Hold operands for the whole search
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      ppm_q  <= ppm;
      band_q <= band;
    end
    acc   <= acc_next;
    level <= level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= busy_next;
      done <= done_next;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

[hw/rtl/lbsd_scan.sv]
// Pump PWM and charlieplex scan positions with their line lookups.
module lbsd_scan (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [15:0] pump_pattern,
  input  logic [7:0]  pattern,
  output logic        pump_bit,
  output logic [2:0]  drive,
  output logic [2:0]  common
);
  import lbsd_pkg::*;

  logic [3:0] pump_position;
  logic [2:0] scan_position;
  logic       led_lit;

  // Look up the lines for the current position
  assign pump_bit = pump_pattern[pump_position];
  assign led_lit  = pattern[scan_position];
  assign drive    = led_lit ? DRIVE_ROM[scan_position]  : 3'd0;
  assign common   = led_lit ? COMMON_ROM[scan_position] : 3'd0;

  // Advance both positions on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      pump_position <= '0;
      scan_position <= '0;
    end else if (step) begin
      pump_position <= pump_position + 1'b1;
      scan_position <= scan_position + 1'b1;
    end
  end

endmodule

[hw/rtl/led_bargraph_scan_driver_unit.sv]
// Top level of the LED bar graph scan driver with pump PWM.
// The result of a scan tick or a non-normal update is registered in the cycle after the
// transfer; a normal (bar graph) update waits on the level search, which adds the selected
// band threshold and compares it with the CO2 reading once per cycle up to six times. The
// block accepts one item at a time: in_ready is high when no search is running and the
// output register is empty or being drained. The battery threshold register may be written
// at any time the block is idle and takes effect on the next update.
module led_bargraph_scan_driver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] pump_pattern,
  input  logic [2:0]  mode,
  input  logic [19:0] co2_ppm,
  input  logic [9:0]  thumbwheel,
  input  logic [9:0]  battery_level,
  input  logic        alarm_flash,
  input  logic        battery_flash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pump_on,
  output logic [2:0]  drive_lines,
  output logic [2:0]  common_lines,
  output logic [7:0]  led_pattern,
  output logic        alarm_sound
);
  import lbsd_pkg::*;

  lbsd_state_t        state;
  lbsd_state_t        state_next;
  logic [9:0]         threshold;
  logic [7:0]         pattern_reg;
  logic [7:0]         pattern_reg_next;
  logic [2:0]         anim_counter;
  logic [2:0]         anim_counter_next;
  logic               alarm_reg;
  logic               alarm_reg_next;
  logic               out_valid_next;
  logic               pump_on_next;
  logic [2:0]         drive_lines_next;
  logic [2:0]         common_lines_next;
  logic               aflash_q;
  logic               batt_on_q;
  logic               accept;
  logic               tick;
  logic               scan_pump_bit;
  logic [2:0]         scan_drive;
  logic [2:0]         scan_common;
  logic [3:0]         band_sel;
  logic [BAND_IW-1:0] band_idx;
  logic [BAND_W-1:0]  band_value;
  lbsd_lvl_ctl_t      lvl_ctl;
  lbsd_lvl_sts_t      lvl_sts;
  logic [LEVEL_W-1:0] level;
  logic [7:0]         bar_pattern;

  assign in_ready = (state == ST_IDLE) && !lvl_sts.busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign tick     = accept && !kind;

  // Select the band, saturating past the end of the table
  assign band_sel = thumbwheel[8:5];
  always_comb begin
    if (int'(band_sel) > BAND_COUNT - 1) begin
      band_idx = BAND_IW'(BAND_COUNT - 1);
    end else begin
      band_idx = BAND_IW'(band_sel);
    end
  end
  assign band_value = BAND_TABLE[band_idx];

  lbsd_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (tick),
    .pump_pattern (pump_pattern),
    .pattern      (pattern_reg),
    .pump_bit     (scan_pump_bit),
    .drive        (scan_drive),
    .common       (scan_common)
  );

  lbsd_level_unit u_level (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lvl_ctl),
    .ppm   (co2_ppm),
    .band  (band_value),
    .sts   (lvl_sts),
    .level (level)
  );

  // Compose the bar graph from the finished level
  always_comb begin
    bar_pattern = LEVEL_ROM[level];
    if ((level == LEVEL_MAX) && aflash_q) begin
      bar_pattern = bar_pattern | LED_ALARM;
    end
    if (batt_on_q) begin
      bar_pattern = bar_pattern | LED_BATTERY;
    end
  end

  // Sequence items and build the next result
  always_comb begin
    state_next        = state;
    pattern_reg_next  = pattern_reg;
    anim_counter_next = anim_counter;
    alarm_reg_next    = alarm_reg;
    out_valid_next    = out_valid && !out_ready;
    pump_on_next      = pump_on;
    drive_lines_next  = drive_lines;
    common_lines_next = common_lines;
    lvl_ctl.start     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          pump_on_next      = 1'b0;
          drive_lines_next  = 3'd0;
          common_lines_next = 3'd0;
          out_valid_next    = 1'b1;
          if (!kind) begin
            pump_on_next      = scan_pump_bit;
            drive_lines_next  = scan_drive;
            common_lines_next = scan_common;
          end else begin
            case (mode)
              MODE_BEEP: begin
                pattern_reg_next = PAT_ALL;
              end
              MODE_POWER_UP: begin
                anim_counter_next = ANIM_START;
              end
              MODE_AIR_ZERO: begin
                pattern_reg_next  = anim_counter[2] ? PAT_AIR_HI : PAT_AIR_LO;
                anim_counter_next = anim_counter - 1'b1;
              end
              MODE_ZERO_CHECK: begin
                pattern_reg_next  = anim_counter[2] ? PAT_ZC_HI : PAT_ZC_LO;
                anim_counter_next = anim_counter - 1'b1;
              end
              MODE_SLEEP: begin
                pattern_reg_next = PAT_OFF;
              end
              default: begin
                out_valid_next = 1'b0;
                lvl_ctl.start  = 1'b1;
                state_next     = ST_CALC;
              end
            endcase
          end
        end
      end
      ST_CALC: begin
        if (lvl_sts.done) begin
          pattern_reg_next = bar_pattern;
          alarm_reg_next   = (level == LEVEL_MAX);
          out_valid_next   = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the LED flags of a bar graph update
  always_ff @(posedge clk) begin
    if (lvl_ctl.start) begin
      aflash_q  <= alarm_flash;
      batt_on_q <= (battery_level > threshold) || battery_flash;
    end
    pump_on      <= pump_on_next;
    drive_lines  <= drive_lines_next;
    common_lines <= common_lines_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      threshold    <= THRESH_DEFAULT;
      pattern_reg  <= PAT_OFF;
      anim_counter <= '0;
      alarm_reg    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      pattern_reg  <= pattern_reg_next;
      anim_counter <= anim_counter_next;
      alarm_reg    <= alarm_reg_next;
      out_valid    <= out_valid_next;
      if (cfg_we) begin
        threshold <= cfg_data;
      end
    end
  end

  assign led_pattern = pattern_reg;
  assign alarm_sound = alarm_reg;

endmodule

[tb/sv/led_scan_checker.sv]
// Checker for the LED bar graph scan driver: predicts each result and compares it.
module led_scan_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [15:0] pump_pattern,
  input  logic [2:0]  mode,
  input  logic [19:0] co2_ppm,
  input  logic [9:0]  thumbwheel,
  input  logic [9:0]  battery_level,
  input  logic        alarm_flash,
  input  logic        battery_flash,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        pump_on,
  input  logic [2:0]  drive_lines,
  input  logic [2:0]  common_lines,
  input  logic [7:0]  led_pattern,
  input  logic        alarm_sound,
  output int          fail_count,
  output int          outstanding
);
  import lbsd_pkg::*;

  localparam logic       KIND_TICK    = 1'b0;
  localparam logic [9:0] THRESH_RESET = 10'd512;
  localparam logic [2:0] ANIM_RELOAD  = 3'd7;
  localparam int         LEVEL_FULL   = 6;

  // Charlieplex line pairs per scan position
  localparam logic [2:0] DRV_LINES [8] = '{3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd1, 3'd5, 3'd1};
  localparam logic [2:0] COM_LINES [8] = '{3'd6, 3'd1, 3'd3, 3'd5, 3'd6, 3'd3, 3'd5, 3'd6};

  // Bar graph LEDs lit per level
  localparam logic [7:0] BAR_LEDS [7] = '{8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF9, 8'hFC};

  typedef struct packed {
    logic       pump;
    logic [2:0] drive;
    logic [2:0] common;
    logic [7:0] leds;
    logic       alarm;
  } scan_result_t;

  // Predicted display state
  logic [7:0]   leds_q;
  logic [2:0]   anim_q;
  logic [2:0]   scan_q;
  logic [3:0]   pump_q;
  logic         alarm_q;
  logic [9:0]   batt_thresh;
  int unsigned  band_div [BAND_COUNT];
  scan_result_t pending_results [$];
  scan_result_t want;
  int           errs = 0;

  // Band divisors: 250 + i*4750/(BAND_COUNT-1), rounded to nearest
  initial begin
    for (int i = 0; i < BAND_COUNT; i++) begin
      band_div[i] = (250 * 2 * (BAND_COUNT - 1) + i * 4750 * 2 + (BAND_COUNT - 1))
                    / (2 * (BAND_COUNT - 1));
    end
  end

  // Advance the predicted state by one transfer and return its result
  function automatic scan_result_t next_result(input logic k, input logic [15:0] pp,
                                               input logic [2:0] md, input logic [19:0] ppm,
                                               input logic [9:0] thumb, input logic [9:0] batt,
                                               input logic af, input logic bf);
    scan_result_t r;
    int unsigned  lvl;
    int unsigned  bi;
    r = '0;
    if (k == KIND_TICK) begin
      r.pump = pp[pump_q];
      pump_q = pump_q + 4'd1;
      if (leds_q[scan_q]) begin
        r.drive  = DRV_LINES[scan_q];
        r.common = COM_LINES[scan_q];
      end
      scan_q = scan_q + 3'd1;
    end else begin
      case (md)
        MODE_BEEP:     leds_q = 8'hFF;
        MODE_POWER_UP: anim_q = ANIM_RELOAD;
        MODE_AIR_ZERO: begin
          leds_q = anim_q[2] ? 8'h54 : 8'hA8;
          anim_q = anim_q - 3'd1;
        end
        MODE_ZERO_CHECK: begin
          leds_q = anim_q[2] ? 8'h1C : 8'hE0;
          anim_q = anim_q - 3'd1;
        end
        MODE_SLEEP:    leds_q = 8'h00;
        default: begin
          // bar graph for the normal mode and the two unused codes
          bi = thumb[8:5];
          if (bi > BAND_COUNT - 1) bi = BAND_COUNT - 1;
          lvl = ppm / band_div[bi];
          if (lvl > LEVEL_FULL) lvl = LEVEL_FULL;
          leds_q  = BAR_LEDS[lvl];
          alarm_q = (lvl == LEVEL_FULL);
          if (lvl == LEVEL_FULL && af) leds_q[0] = 1'b1;
          if (batt > batt_thresh || bf) leds_q[1] = 1'b1;
        end
      endcase
    end
    r.leds  = leds_q;
    r.alarm = alarm_q;
    return r;
  endfunction

  function automatic void check_field(input string fname, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, exp_v, got_v);
      errs++;
    end
  endfunction

  // Match output transfers against the oldest prediction, then record new input transfers
  always @(posedge clk) begin
    if (rst) begin
      leds_q      = '0;
      anim_q      = '0;
      scan_q      = '0;
      pump_q      = '0;
      alarm_q     = 1'b0;
      batt_thresh = THRESH_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we) batt_thresh = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual leds %0h", $time, led_pattern);
          errs++;
        end else begin
          want = pending_results.pop_front();
          check_field("pump_on", want.pump, pump_on);
          check_field("drive_lines", want.drive, drive_lines);
          check_field("common_lines", want.common, common_lines);
          check_field("led_pattern", want.leds, led_pattern);
          check_field("alarm_sound", want.alarm, alarm_sound);
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(next_result(kind, pump_pattern, mode, co2_ppm, thumbwheel,
                                              battery_level, alarm_flash, battery_flash));
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= errs;
  end

endmodule

[tb/sv/tb_led_bargraph_scan_driver_unit.sv]
// Testbench top for the LED bar graph scan driver: stimulus, flow control and verdict.
module tb_led_bargraph_scan_driver_unit;
  import lbsd_pkg::*;

  localparam logic       KIND_TICK   = 1'b0;
  localparam logic       KIND_UPDATE = 1'b1;
  localparam logic [2:0] MODE_BAR    = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 16;
  localparam int PHASE_ITEMS = 430;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_style_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] pump;
    logic [2:0]  mode;
    logic [19:0] ppm;
    logic [9:0]  thumb;
    logic [9:0]  batt;
    logic        af;
    logic        bf;
  } scan_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [15:0] pump_pattern = '0;
  logic [2:0]  mode = '0;
  logic [19:0] co2_ppm = '0;
  logic [9:0]  thumbwheel = '0;
  logic [9:0]  battery_level = '0;
  logic        alarm_flash = 1'b0;
  logic        battery_flash = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        pump_on;
  logic [2:0]  drive_lines;
  logic [2:0]  common_lines;
  logic [7:0]  led_pattern;
  logic        alarm_sound;

  int   fail_count;
  int   outstanding;
  int   idle_cycles = 0;
  int   burst_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  always #6 clk = ~clk;

  led_bargraph_scan_driver_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .pump_pattern(pump_pattern),
    .mode(mode), .co2_ppm(co2_ppm), .thumbwheel(thumbwheel),
    .battery_level(battery_level), .alarm_flash(alarm_flash),
    .battery_flash(battery_flash), .out_valid(out_valid), .out_ready(out_ready),
    .pump_on(pump_on), .drive_lines(drive_lines), .common_lines(common_lines),
    .led_pattern(led_pattern), .alarm_sound(alarm_sound)
  );

  led_scan_checker scoreboard (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .pump_pattern(pump_pattern),
    .mode(mode), .co2_ppm(co2_ppm), .thumbwheel(thumbwheel),
    .battery_level(battery_level), .alarm_flash(alarm_flash),
    .battery_flash(battery_flash), .out_valid(out_valid), .out_ready(out_ready),
    .pump_on(pump_on), .drive_lines(drive_lines), .common_lines(common_lines),
    .led_pattern(led_pattern), .alarm_sound(alarm_sound),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // Drop the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic scan_item_t make_item(input logic k, input logic [15:0] pp,
                                           input logic [2:0] md, input logic [19:0] ppm,
                                           input logic [9:0] thumb, input logic [9:0] batt,
                                           input logic af, input logic bf);
    scan_item_t it;
    it = '{kind: k, pump: pp, mode: md, ppm: ppm, thumb: thumb, batt: batt, af: af, bf: bf};
    return it;
  endfunction

  // Mostly meaningful updates, with ticks to scan out the resulting pattern
  function automatic scan_item_t random_item();
    scan_item_t  it;
    int unsigned pick;
    it.kind  = KIND_TICK;
    it.pump  = 16'($urandom);
    it.mode  = 3'($urandom);
    it.ppm   = 20'($urandom);
    it.thumb = 10'($urandom);
    it.batt  = 10'($urandom);
    it.af    = 1'($urandom);
    it.bf    = 1'($urandom);
    if ($urandom_range(0, 99) >= 45) begin
      it.kind = KIND_UPDATE;
      pick = $urandom_range(0, 99);
      if (pick < 10)      it.mode = MODE_BEEP;
      else if (pick < 22) it.mode = MODE_POWER_UP;
      else if (pick < 36) it.mode = MODE_AIR_ZERO;
      else if (pick < 50) it.mode = MODE_ZERO_CHECK;
      else if (pick < 55) it.mode = MODE_SLEEP;
      else if (pick < 60) it.mode = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
      else                it.mode = MODE_BAR;
      // keep most readings in the range where the level changes
      pick = $urandom_range(0, 9);
      if (pick < 4)      it.ppm = 20'($urandom_range(0, 3000));
      else if (pick < 8) it.ppm = 20'($urandom_range(0, 16000));
    end
    return it;
  endfunction

  // Offer one item in bursts with random gaps; hold it until the transfer
  task automatic send(input scan_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid      <= 1'b1;
    kind          <= it.kind;
    pump_pattern  <= it.pump;
    mode          <= it.mode;
    co2_ppm       <= it.ppm;
    thumbwheel    <= it.thumb;
    battery_level <= it.batt;
    alarm_flash   <= it.af;
    battery_flash <= it.bf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering and let every predicted result drain
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [9:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Receiver: stall patterns in segments, plus one long hold-off
  initial begin
    rx_style_t   style;
    int unsigned seg;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      style = rx_style_t'($urandom_range(0, 3));
      seg   = $urandom_range(16, 160);
      for (int n = 0; n < seg; n++) begin
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (style)
          RX_OPEN:    out_ready <= 1'b1;
          RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= (n % 5 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Pump bits and blank scan from reset
    send(make_item(KIND_TICK, 16'hFFFF, MODE_BEEP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_TICK, 16'h0000, MODE_SPARE7, 20'hFFFFF, 10'h3FF, 10'h3FF, 1'b1, 1'b1));
    // All LEDs on, then scan several positions lit
    send(make_item(KIND_UPDATE, 16'h0, MODE_BEEP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_TICK, 16'hAAAA, MODE_BEEP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_TICK, 16'h5555, MODE_BEEP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_TICK, 16'hFFFF, MODE_BEEP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_TICK, 16'h0000, MODE_BEEP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    // Powering up holds the pattern and reloads the animation counter
    send(make_item(KIND_UPDATE, 16'h0, MODE_POWER_UP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    // Alternate animations down through the counter, wrapping from zero
    send(make_item(KIND_UPDATE, 16'h0, MODE_AIR_ZERO, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_ZERO_CHECK, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_ZERO_CHECK, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_AIR_ZERO, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_AIR_ZERO, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_ZERO_CHECK, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_ZERO_CHECK, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_AIR_ZERO, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_SLEEP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    // Bar graph edges in the lowest band and battery at the default threshold
    send(make_item(KIND_UPDATE, 16'h0, MODE_BAR, 20'd249, 10'd0, 10'd512, 1'b1, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_BAR, 20'd250, 10'd0, 10'd513, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_BAR, 20'd1500, 10'd0, 10'd0, 1'b1, 1'b1));
    // Alarm is held outside the bar graph
    send(make_item(KIND_UPDATE, 16'h0, MODE_POWER_UP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    // Highest band, just below full scale, then full scale on a spare code
    send(make_item(KIND_UPDATE, 16'h0, MODE_BAR, 20'd15287, 10'h3FF, 10'd0, 1'b1, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_SPARE7, 20'hFFFFF, 10'h1E0, 10'h3FF, 1'b0, 1'b0));
    send(make_item(KIND_UPDATE, 16'h0, MODE_SPARE6, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    send(make_item(KIND_TICK, 16'h8000, MODE_BEEP, 20'd0, 10'd0, 10'd0, 1'b0, 1'b0));
    settle();

    // Random phases across threshold settings; the first one starts with a long hold-off
    write_threshold(10'd1023);
    hold_req <= 1'b1;
    repeat (PHASE_ITEMS) send(random_item());
    settle();
    write_threshold(10'($urandom_range(1, 1022)));
    repeat (PHASE_ITEMS) send(random_item());
    settle();
    write_threshold(10'd0);
    repeat (PHASE_ITEMS) send(random_item());
    settle();

    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
